FILE: rtl/mtfr_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the monochrome text frame buffer renderer:
// screen and font sizes, command codes and the request/result payload types.
// No dependencies.
package mtfr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int FONT_WORDS    = 4096;
    localparam int FRAME_BYTES   = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;

    localparam int FB_W = $clog2(FRAME_BYTES);
    localparam int FA_W = $clog2(FONT_WORDS);

    // Printable character range and glyph row layout.
    localparam logic [7:0]  CHAR_FIRST = 8'd32;
    localparam logic [7:0]  CHAR_LAST  = 8'd126;
    localparam logic [15:0] GLYPH_MSB  = 16'h8000;
    localparam logic [7:0]  BYTE_ONES  = 8'hFF;

    // Configuration register indexes (address bit 2).
    localparam logic REG_GLYPH_WIDTH  = 1'b0;
    localparam logic REG_GLYPH_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        FUNC_LOAD_FONT  = 3'd0,
        FUNC_SET_CURSOR = 3'd1,
        FUNC_DRAW_PIXEL = 3'd2,
        FUNC_FILL       = 3'd3,
        FUNC_WRITE_CHAR = 3'd4,
        FUNC_READ_BYTE  = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  x_coord;
        logic [7:0]  y_coord;
        logic        pixel_color;
        logic [7:0]  char_code;
        logic [11:0] font_index;
        logic [15:0] font_row;
        logic [9:0]  byte_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [7:0] cursor_x;
        logic [5:0] cursor_y;
        logic       status;
    } t_result;

endpackage

FILE: rtl/mono_text_framebuffer_renderer.sv
`timescale 1ns / 1ps
// Monochrome page-organised frame store with a loadable font and text cursor.
// Depends on mtfr_pkg.

// A request is taken when start is high and busy is low; exactly one result
// follows on o_result, flagged by o_done for a single cycle, and the receiver
// must take it then. Font load, cursor set and rejected requests answer in the
// cycle after the request; a byte read answers after state S_RDB, a pixel after
// states S_PRD and S_PWR. A character walks its W x H glyph row by row: the
// glyph base address is first reduced into the font store in S_MOD (at most one
// reduction step, none for the default font size), then each row takes one font
// store read in S_FRD and each glyph pixel one read-modify-write of a frame byte
// in S_PRD and S_PWR. A fill writes one frame byte a cycle over all FRAME_BYTES
// (1024) bytes. After reset the same sweep clears the frame store with busy
// high; configuration writes are taken throughout.
module mono_text_framebuffer_renderer
    import mtfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_cmd        i_cmd,
    output logic        busy,
    output logic        o_done,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PROD_W = 13;
    localparam logic [PROD_W:0]  FW_CMP    = (PROD_W + 1)'(FONT_WORDS);
    localparam logic [FB_W-1:0]  FB_LAST   = FB_W'(FRAME_BYTES - 1);
    localparam logic [FA_W-1:0]  FA_LAST   = FA_W'(FONT_WORDS - 1);
    localparam logic [7:0]       SW8       = 8'(SCREEN_WIDTH);
    localparam logic [8:0]       SW9       = 9'(SCREEN_WIDTH);
    localparam logic [6:0]       SH7       = 7'(SCREEN_HEIGHT);
    localparam logic [7:0]       SH8       = 8'(SCREEN_HEIGHT);
    localparam logic [10:0]      FB_CMP    = 11'(FRAME_BYTES);
    localparam logic [12:0]      FI_CMP    = 13'(FONT_WORDS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_FRD   = 7'b0001000,
        S_PRD   = 7'b0010000,
        S_PWR   = 7'b0100000,
        S_RDB   = 7'b1000000
    } t_state;

    // Control registers
    t_state            r_state,     n_state;
    logic [4:0]        r_gw,        n_gw;
    logic [5:0]        r_gh,        n_gh;
    logic [7:0]        r_text_col,  n_text_col;
    logic [5:0]        r_text_row,  n_text_row;
    logic              r_is_fill,   n_is_fill;
    logic [FB_W-1:0]   r_clr_cnt,   n_clr_cnt;
    logic [7:0]        r_fill_val,  n_fill_val;
    logic              r_done,      n_done;

    // Working registers
    logic              r_is_char,   n_is_char;
    logic [PROD_W-1:0] r_prod,      n_prod;
    logic [FA_W-1:0]   r_faddr,     n_faddr;
    logic [4:0]        r_c,         n_c;
    logic [5:0]        r_r,         n_r;
    logic [7:0]        r_px_x,      n_px_x;
    logic [5:0]        r_px_y,      n_px_y;
    logic              r_px_val,    n_px_val;
    logic [FB_W-1:0]   r_waddr,     n_waddr;
    logic [7:0]        r_wmask,     n_wmask;
    logic              r_wbit,      n_wbit;
    t_result           r_result,    n_result;

    // Memories
    logic [7:0]        r_frame_mem [FRAME_BYTES];
    logic [15:0]       r_font_mem  [FONT_WORDS];
    logic [7:0]        r_fb_q;
    logic [15:0]       r_font_q;

    logic              fb_we;
    logic [FB_W-1:0]   fb_waddr;
    logic [7:0]        fb_wdata;
    logic [FB_W-1:0]   fb_raddr;
    logic [FB_W-1:0]   px_addr;
    logic              font_we;

    logic              accept;
    logic              cfg_wr;
    logic              fin;
    logic              fin_status;
    logic [7:0]        fin_byte;
    logic              glyph_bit;
    logic              pix;
    logic              xy_ok;
    logic              code_ok;
    logic              space_ok;

    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite;
    assign busy    = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_result = r_result;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_GLYPH_HEIGHT) ? {26'd0, r_gh} : {27'd0, r_gw};

    assign xy_ok    = (i_cmd.x_coord < SW8) && (i_cmd.y_coord < SH8);
    assign code_ok  = (i_cmd.char_code >= CHAR_FIRST) && (i_cmd.char_code <= CHAR_LAST);
    assign space_ok = (({1'b0, r_text_col} + 9'(r_gw)) <= SW9)
                   && (({1'b0, r_text_row} + 7'(r_gh)) <= SH7);

    // Byte address of the current pixel: page times width plus column.
    assign px_addr = FB_W'(r_px_y[5:3]) * FB_W'(SCREEN_WIDTH) + FB_W'(r_px_x);

    // Glyph columns past the font word read as clear, painted inverse.
    assign glyph_bit = r_c[4] ? 1'b0 : |(r_font_q & (GLYPH_MSB >> r_c[3:0]));
    assign pix       = r_is_char ? ~(glyph_bit ^ r_px_val) : r_px_val;

    assign fb_raddr = (r_state == S_IDLE) ? FB_W'(i_cmd.byte_index) : px_addr;
    assign font_we  = accept && (i_cmd.func == FUNC_LOAD_FONT)
                   && ({1'b0, i_cmd.font_index} < FI_CMP);

    always_comb begin
        n_state    = r_state;
        n_gw       = r_gw;
        n_gh       = r_gh;
        n_text_col = r_text_col;
        n_text_row = r_text_row;
        n_is_fill  = r_is_fill;
        n_clr_cnt  = r_clr_cnt;
        n_fill_val = r_fill_val;
        n_is_char  = r_is_char;
        n_prod     = r_prod;
        n_faddr    = r_faddr;
        n_c        = r_c;
        n_r        = r_r;
        n_px_x     = r_px_x;
        n_px_y     = r_px_y;
        n_px_val   = r_px_val;
        n_waddr    = r_waddr;
        n_wmask    = r_wmask;
        n_wbit     = r_wbit;
        n_result   = r_result;
        n_done     = 1'b0;
        fin        = 1'b0;
        fin_status = 1'b0;
        fin_byte   = 8'd0;
        fb_we      = 1'b0;
        fb_waddr   = r_waddr;
        fb_wdata   = r_wbit ? (r_fb_q | r_wmask) : (r_fb_q & ~r_wmask);

        if (cfg_wr) begin
            if (paddr[2] == REG_GLYPH_HEIGHT) begin
                n_gh = pwdata[5:0];
            end else begin
                n_gw = pwdata[4:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.func)
                        FUNC_LOAD_FONT: begin
                            fin        = 1'b1;
                            fin_status = !font_we;
                        end
                        FUNC_SET_CURSOR: begin
                            fin        = 1'b1;
                            fin_status = !xy_ok;
                            if (xy_ok) begin
                                n_text_col = i_cmd.x_coord;
                                n_text_row = i_cmd.y_coord[5:0];
                            end
                        end
                        FUNC_DRAW_PIXEL: begin
                            if (xy_ok) begin
                                n_px_x    = i_cmd.x_coord;
                                n_px_y    = i_cmd.y_coord[5:0];
                                n_px_val  = i_cmd.pixel_color;
                                n_is_char = 1'b0;
                                n_state   = S_PRD;
                            end else begin
                                fin        = 1'b1;
                                fin_status = 1'b1;
                            end
                        end
                        FUNC_FILL: begin
                            n_fill_val = i_cmd.pixel_color ? BYTE_ONES : 8'd0;
                            n_clr_cnt  = '0;
                            n_is_fill  = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        FUNC_WRITE_CHAR: begin
                            if (!code_ok || !space_ok) begin
                                fin        = 1'b1;
                                fin_status = 1'b1;
                            end else if (r_gw == 5'd0 || r_gh == 6'd0) begin
                                // nothing to paint, still advance
                                n_text_col = r_text_col + 8'(r_gw);
                                fin        = 1'b1;
                            end else begin
                                n_prod    = PROD_W'(7'(i_cmd.char_code - CHAR_FIRST))
                                          * PROD_W'(r_gh);
                                n_is_char = 1'b1;
                                n_px_val  = i_cmd.pixel_color;
                                n_c       = 5'd0;
                                n_r       = 6'd0;
                                n_px_x    = r_text_col;
                                n_px_y    = r_text_row;
                                n_state   = S_MOD;
                            end
                        end
                        FUNC_READ_BYTE: begin
                            if ({1'b0, i_cmd.byte_index} < FB_CMP) begin
                                n_state = S_RDB;
                            end else begin
                                fin        = 1'b1;
                                fin_status = 1'b1;
                            end
                        end
                        default: begin
                            fin        = 1'b1;
                            fin_status = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                fb_we    = 1'b1;
                fb_waddr = r_clr_cnt;
                fb_wdata = r_fill_val;
                if (r_clr_cnt == FB_LAST) begin
                    n_state   = S_IDLE;
                    n_is_fill = 1'b0;
                    fin       = r_is_fill;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            S_MOD: begin
                // reduce the glyph base address into the font store
                if ({1'b0, r_prod} >= FW_CMP) begin
                    n_prod = PROD_W'({1'b0, r_prod} - FW_CMP);
                end else begin
                    n_faddr = FA_W'(r_prod);
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                n_state = S_PRD;
            end
            S_PRD: begin
                n_waddr = px_addr;
                n_wmask = 8'd1 << r_px_y[2:0];
                n_wbit  = pix;
                n_state = S_PWR;
            end
            S_PWR: begin
                fb_we = 1'b1;
                if (!r_is_char) begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end else if (r_c != r_gw - 5'd1) begin
                    n_c     = r_c + 5'd1;
                    n_px_x  = r_px_x + 8'd1;
                    n_state = S_PRD;
                end else if (r_r != r_gh - 6'd1) begin
                    n_r     = r_r + 6'd1;
                    n_px_y  = r_px_y + 6'd1;
                    n_c     = 5'd0;
                    n_px_x  = r_text_col;
                    n_faddr = (r_faddr == FA_LAST) ? '0 : r_faddr + 1'b1;
                    n_state = S_FRD;
                end else begin
                    n_text_col = r_text_col + 8'(r_gw);
                    n_is_char  = 1'b0;
                    fin        = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RDB: begin
                fin      = 1'b1;
                fin_byte = r_fb_q;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done             = 1'b1;
            n_result.read_byte = fin_byte;
            n_result.cursor_x  = n_text_col;
            n_result.cursor_y  = n_text_row;
            n_result.status    = fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_gw       <= 5'd7;
            r_gh       <= 6'd10;
            r_text_col <= 8'd0;
            r_text_row <= 6'd0;
            r_is_fill  <= 1'b0;
            r_clr_cnt  <= '0;
            r_fill_val <= 8'd0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_gw       <= n_gw;
            r_gh       <= n_gh;
            r_text_col <= n_text_col;
            r_text_row <= n_text_row;
            r_is_fill  <= n_is_fill;
            r_clr_cnt  <= n_clr_cnt;
            r_fill_val <= n_fill_val;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_char <= n_is_char;
        r_prod    <= n_prod;
        r_faddr   <= n_faddr;
        r_c       <= n_c;
        r_r       <= n_r;
        r_px_x    <= n_px_x;
        r_px_y    <= n_px_y;
        r_px_val  <= n_px_val;
        r_waddr   <= n_waddr;
        r_wmask   <= n_wmask;
        r_wbit    <= n_wbit;
        r_result  <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_frame_mem[fb_waddr] <= fb_wdata;
        end
        r_fb_q <= r_frame_mem[fb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (font_we) begin
            r_font_mem[FA_W'(i_cmd.font_index)] <= i_cmd.font_row;
        end
        r_font_q <= r_font_mem[r_faddr];
    end

`ifndef SYNTHESIS
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_text_col <= SW8)
        else $error("text cursor column beyond screen width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_text_row} < SH7)
        else $error("text cursor row beyond screen height");

    a_pix_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRD) |-> (r_px_x < SW8) && ({1'b0, r_px_y} < SH7))
        else $error("pixel write outside the screen");

    a_pixel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PWR && !r_is_char) |=> o_done)
        else $error("pixel request finished without a result");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.func == FUNC_READ_BYTE && {1'b0, i_cmd.byte_index} < FB_CMP)
        |=> ##1 o_done)
        else $error("byte read result late");
`endif

endmodule
